@@ hdl/sws_pkg.sv @@
// shared types, constants and sizes for the stack with search
`timescale 1ns / 1ps
`default_nettype none

package sws_pkg;

  // storage sizing
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the ports
  localparam int FIELD_W = 32;
  localparam int POS_W   = 7;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;

  // derived widths
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 3'd0,
    FN_POP  = 3'd1,
    FN_PEEK = 3'd2,
    FN_FIND = 3'd3,
    FN_READ = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_SCAN
  } state_e;

  // one write and one read port into the entry store
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    addr_t rd_addr;
  } store_req_t;

endpackage

`default_nettype wire

@@ hdl/sws_store.sv @@
// entry store: single write port, single registered read port
`timescale 1ns / 1ps
`default_nettype none

module sws_store (
  input  wire                      clk_i,
  input  wire sws_pkg::store_req_t req_i,
  output sws_pkg::word_t           rd_data_o
);

  sws_pkg::word_t mem_q [sws_pkg::DEPTH];
  sws_pkg::word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem_q[req_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ hdl/stack_with_search_core.sv @@
// top level of the stack with search: request sequencer, counters and result register
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                      payload
// -------   ---  -----------------------------  ----------------------------------------------
// request   in   in_valid_i / in_stall_o        func_i, value_i, position_i
// result    out  out_valid_o / out_stall_i      status_o, data_o, found_position_o, fill_count_o
//
// sequencing: push, unused codes and requests refused on a check (empty, full, bad position)
//   finish in S_EXEC; pop, peek and read pass through S_WAIT for one store read;
//   find walks S_SCAN from the top entry down,
//   one stored entry per cycle through the single comparator
// one request in flight at a time; the result register frees the request side as it drains
// reset: asynchronous, active low, clears the fill count and the sequencer; store contents persist
// stalls: out_stall_i holds the result register and keeps new requests out until it drains

module stack_with_search_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,

  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [sws_pkg::FUNC_W-1:0]      func_i,
  input  wire  signed [sws_pkg::FIELD_W-1:0] value_i,
  input  wire  [sws_pkg::POS_W-1:0]       position_i,

  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [sws_pkg::STAT_W-1:0]      status_o,
  output logic signed [sws_pkg::FIELD_W-1:0] data_o,
  output logic [sws_pkg::POS_W-1:0]       found_position_o,
  output logic [sws_pkg::POS_W-1:0]       fill_count_o
);

  localparam int AW = sws_pkg::ADDR_W;
  localparam int CW = sws_pkg::CNT_W;
  localparam int MW = sws_pkg::CMP_W;
  localparam int PW = sws_pkg::POS_W;
  localparam int FW = sws_pkg::FIELD_W;
  localparam int DW = sws_pkg::DATA_WIDTH;

  // sequencer and count
  sws_pkg::state_e  state_q, state_d;
  sws_pkg::cnt_t    count_q, count_d;

  // captured request
  sws_pkg::func_e   func_q;
  sws_pkg::word_t   value_q;
  logic [PW-1:0]    pos_q;

  // scan position (1-based from top) and address of the data now on the read port
  sws_pkg::cnt_t    idx_q, idx_d;
  sws_pkg::addr_t   rd_addr_q;

  // result register
  logic             out_valid_q;
  sws_pkg::status_e status_q;
  logic [FW-1:0]    data_q;
  logic [PW-1:0]    fpos_q;
  logic [PW-1:0]    fill_q;

  // finishing strobe and the result it carries
  logic             fin;
  sws_pkg::status_e fin_status;
  logic [FW-1:0]    fin_data;
  logic [PW-1:0]    fin_pos;

  sws_pkg::store_req_t store_req;
  sws_pkg::word_t      rd_data;

  logic             in_xfer;
  logic             out_xfer;
  logic             empty;
  logic             full;
  logic             hit;
  logic [MW-1:0]    pos_ext;
  logic [MW-1:0]    cnt_ext;

  // ready only when idle and the result register is free or draining this cycle
  assign in_stall_o = (state_q != sws_pkg::S_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  assign empty   = (count_q == '0);
  assign full    = (count_q >= CW'(sws_pkg::DEPTH));
  assign pos_ext = MW'(pos_q);
  assign cnt_ext = MW'(count_q);

  // the shared comparator: one stored entry against the search word per cycle
  assign hit = (rd_data == value_q);

  sws_store u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sws_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q  <= sws_pkg::func_e'(func_i);
      value_q <= DW'($unsigned(value_i));
      pos_q   <= position_i;
    end
    idx_q     <= idx_d;
    rd_addr_q <= store_req.rd_addr;
    if (fin) begin
      status_q <= fin_status;
      data_q   <= fin_data;
      fpos_q   <= fin_pos;
      fill_q   <= PW'(count_d);
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    fin        = 1'b0;
    fin_status = sws_pkg::ST_OK;
    fin_data   = '0;
    fin_pos    = '0;

    store_req.wr_en   = 1'b0;
    store_req.wr_addr = AW'(count_q);
    store_req.wr_data = value_q;
    store_req.rd_addr = rd_addr_q;

    case (state_q)
      sws_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_d = sws_pkg::S_EXEC;
        end
      end

      sws_pkg::S_EXEC: begin
        case (func_q)
          sws_pkg::FN_PUSH: begin
            fin = 1'b1;
            if (full) begin
              fin_status = sws_pkg::ST_OVERFLOW;
            end else begin
              store_req.wr_en = 1'b1;
              count_d         = count_q + CW'(1);
            end
          end
          sws_pkg::FN_POP, sws_pkg::FN_PEEK: begin
            if (empty) begin
              fin        = 1'b1;
              fin_status = sws_pkg::ST_EMPTY;
            end else begin
              store_req.rd_addr = AW'(count_q - CW'(1));
              state_d           = sws_pkg::S_WAIT;
            end
          end
          sws_pkg::FN_FIND: begin
            if (empty) begin
              fin        = 1'b1;
              fin_status = sws_pkg::ST_EMPTY;
            end else begin
              // start the walk at the top entry
              store_req.rd_addr = AW'(count_q - CW'(1));
              idx_d             = CW'(1);
              state_d           = sws_pkg::S_SCAN;
            end
          end
          sws_pkg::FN_READ: begin
            if (empty) begin
              fin        = 1'b1;
              fin_status = sws_pkg::ST_EMPTY;
            end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
              fin        = 1'b1;
              fin_status = sws_pkg::ST_NOTFOUND;
            end else begin
              store_req.rd_addr = AW'(cnt_ext - pos_ext);
              state_d           = sws_pkg::S_WAIT;
            end
          end
          default: begin
            // unused codes leave the stack alone
            fin = 1'b1;
          end
        endcase
      end

      sws_pkg::S_WAIT: begin
        fin      = 1'b1;
        fin_data = FW'(rd_data);
        if (func_q == sws_pkg::FN_POP) begin
          count_d = count_q - CW'(1);
        end
      end

      sws_pkg::S_SCAN: begin
        if (hit) begin
          fin     = 1'b1;
          fin_pos = PW'(idx_q);
        end else if (idx_q == count_q) begin
          fin        = 1'b1;
          fin_status = sws_pkg::ST_NOTFOUND;
        end else begin
          // next entry down while this one is compared
          idx_d             = idx_q + CW'(1);
          store_req.rd_addr = rd_addr_q - AW'(1);
        end
      end

      default: begin
        state_d = sws_pkg::S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = sws_pkg::S_IDLE;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign data_o           = $signed(data_q);
  assign found_position_o = fpos_q;
  assign fill_count_o     = fill_q;

  // a finishing request always finds the result register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !out_valid_q)
    else $error("result register overwritten");

  // fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(sws_pkg::DEPTH))
    else $error("fill count above depth");

  // the search walk stays inside the filled part of the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sws_pkg::S_SCAN |-> idx_q != '0 && idx_q <= count_q)
    else $error("scan index out of range");

  // a successful push grows the stack by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.wr_en |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not advance fill count");

  // the count only moves while a request finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin |=> $stable(count_q))
    else $error("fill count changed outside a request");

endmodule

`default_nettype wire
